// ===== design/dhlt_pkg.sv =====
// package: shared constants, tables and types of the link transform block
package dhlt_pkg;
  localparam int TrigFracBits = 14;
  localparam int CordicStages = 16;
  localparam int AngW = 17;
  localparam int LenW = 32;
  localparam int TrigW = 16;
  localparam int AngFull = 46080;
  localparam int AngQuarter = 11520;
  localparam int AngEighth = 5760;
  localparam int ZW = 34;
  localparam int XW = 36;
  localparam logic signed [XW-1:0] CordicGain = 36'sd2608131496;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0: v = 34'sd188743680;  5'd1: v = 34'sd111421900;
      5'd2: v = 34'sd58872272;   5'd3: v = 34'sd29884485;
      5'd4: v = 34'sd15000234;   5'd5: v = 34'sd7507429;
      5'd6: v = 34'sd3754631;    5'd7: v = 34'sd1877430;
      5'd8: v = 34'sd938729;     5'd9: v = 34'sd469366;
      5'd10: v = 34'sd234683;    5'd11: v = 34'sd117342;
      5'd12: v = 34'sd58671;     5'd13: v = 34'sd29335;
      5'd14: v = 34'sd14668;     5'd15: v = 34'sd7334;
      5'd16: v = 34'sd3667;      5'd17: v = 34'sd1833;
      5'd18: v = 34'sd917;       5'd19: v = 34'sd458;
      5'd20: v = 34'sd229;       5'd21: v = 34'sd115;
      5'd22: v = 34'sd57;        5'd23: v = 34'sd29;
      5'd24: v = 34'sd14;        5'd25: v = 34'sd7;
      5'd26: v = 34'sd4;         5'd27: v = 34'sd2;
      5'd28: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0] k;
  } rot_t;

  typedef struct packed {
    rot_t th;
    rot_t al;
    logic signed [LenW-1:0] r;
    logic signed [LenW-1:0] d;
  } lane_t;

  typedef struct packed {
    logic signed [TrigW-1:0] m00, m01, m02;
    logic signed [LenW-1:0] m03;
    logic signed [TrigW-1:0] m10, m11, m12;
    logic signed [LenW-1:0] m13;
    logic m20;
    logic signed [TrigW-1:0] m21, m22;
    logic signed [LenW-1:0] m23;
  } mat_t;
endpackage

// ===== design/dhlt_if.sv =====
// interfaces: valid/ready channels for requests and results
interface dhlt_in_if;
  logic valid, ready;
  logic signed [dhlt_pkg::AngW-1:0] joint_angle, twist_angle;
  logic signed [dhlt_pkg::LenW-1:0] link_length, link_offset;
  modport source(output valid, joint_angle, twist_angle, link_length, link_offset,
                 input ready);
  modport sink(input valid, joint_angle, twist_angle, link_length, link_offset,
               output ready);
endinterface

interface dhlt_out_if;
  logic valid, ready;
  dhlt_pkg::mat_t m;
  modport source(output valid, m, input ready);
  modport sink(input valid, m, output ready);
endinterface

// ===== design/dhlt_cell.sv =====
// cordic cell: one micro-rotation stage for both angles of a request
module dhlt_cell #(
  parameter int Idx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  dhlt_pkg::lane_t lane_i,
  output logic            valid_o,
  output dhlt_pkg::lane_t lane_o
);
  logic valid_q;
  dhlt_pkg::lane_t lane_q, lane_d;

  function automatic dhlt_pkg::rot_t rot(input dhlt_pkg::rot_t a);
    dhlt_pkg::rot_t b;
    logic signed [dhlt_pkg::XW-1:0] dx, dy;
    dx = a.y >>> Idx;
    dy = a.x >>> Idx;
    b = a;
    if (!a.z[dhlt_pkg::ZW-1]) begin
      b.x = a.x - dx; b.y = a.y + dy; b.z = a.z - dhlt_pkg::atan_deg(5'(Idx));
    end else begin
      b.x = a.x + dx; b.y = a.y - dy; b.z = a.z + dhlt_pkg::atan_deg(5'(Idx));
    end
    return b;
  endfunction

  always_comb begin
    lane_d = lane_i;
    lane_d.th = rot(lane_i.th);
    lane_d.al = rot(lane_i.al);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end
  assign valid_o = valid_q;
  assign lane_o = lane_q;
endmodule

// ===== design/dhlt_post.sv =====
// back end: quadrant fix, rounding, products and saturation in two stages
module dhlt_post (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  dhlt_pkg::lane_t lane_i,
  output logic            valid_o,
  output dhlt_pkg::mat_t  mat_o
);
  localparam int S = 32 - dhlt_pkg::TrigFracBits;
  localparam int F = dhlt_pkg::TrigFracBits;
  localparam int PW = 2 * dhlt_pkg::TrigW;
  localparam int LW = dhlt_pkg::LenW + dhlt_pkg::TrigW;
  localparam logic signed [LW-1:0] Max32 = LW'(64'sd2147483647);
  localparam logic signed [LW-1:0] Min32 = -LW'(64'sd2147483648);

  typedef logic signed [dhlt_pkg::TrigW-1:0] tr_t;
  logic v1_q, v2_q;
  tr_t ct_q, st_q, ca_q, sa_q;
  logic signed [dhlt_pkg::LenW-1:0] r_q, d_q;
  dhlt_pkg::mat_t mat_q, mat_d;
  tr_t ct_d, st_d, ca_d, sa_d;

  function automatic tr_t rnd(input logic signed [dhlt_pkg::XW-1:0] v);
    logic signed [dhlt_pkg::XW-1:0] r;
    localparam logic signed [dhlt_pkg::XW-1:0] One = dhlt_pkg::XW'(1) <<< F;
    r = (v + (dhlt_pkg::XW'(1) <<< (S - 1))) >>> S;
    if (r > One) r = One;
    if (r < -One) r = -One;
    return tr_t'(r);
  endfunction

  function automatic void quad(input dhlt_pkg::rot_t a, output tr_t c, output tr_t s);
    unique case (a.k)
      2'd0: begin c = rnd(a.x); s = rnd(a.y); end
      2'd1: begin c = rnd(-a.y); s = rnd(a.x); end
      2'd2: begin c = rnd(-a.x); s = rnd(-a.y); end
      default: begin c = rnd(a.y); s = rnd(-a.x); end
    endcase
  endfunction

  function automatic tr_t mt(input tr_t a, input tr_t b, input logic neg);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b) + (PW'(1) <<< (F - 1))) >>> F;
    return neg ? -tr_t'(p) : tr_t'(p);
  endfunction

  function automatic logic signed [dhlt_pkg::LenW-1:0] ml(
    input logic signed [dhlt_pkg::LenW-1:0] r, input tr_t t);
    logic signed [LW-1:0] p;
    p = (LW'(r) * LW'(t) + (LW'(1) <<< (F - 1))) >>> F;
    if (p > Max32) p = Max32;
    if (p < Min32) p = Min32;
    return dhlt_pkg::LenW'(p);
  endfunction

  always_comb begin
    quad(lane_i.th, ct_d, st_d);
    quad(lane_i.al, ca_d, sa_d);
    mat_d.m00 = ct_q;
    mat_d.m01 = mt(st_q, ca_q, 1'b1);
    mat_d.m02 = mt(st_q, sa_q, 1'b0);
    mat_d.m03 = ml(r_q, ct_q);
    mat_d.m10 = st_q;
    mat_d.m11 = mt(ct_q, ca_q, 1'b0);
    mat_d.m12 = mt(ct_q, sa_q, 1'b1);
    mat_d.m13 = ml(r_q, st_q);
    mat_d.m20 = 1'b0;
    mat_d.m21 = sa_q;
    mat_d.m22 = ca_q;
    mat_d.m23 = d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ct_q <= ct_d; st_q <= st_d; ca_q <= ca_d; sa_q <= sa_d;
      r_q <= lane_i.r; d_q <= lane_i.d; mat_q <= mat_d;
    end
  end
  assign valid_o = v2_q;
  assign mat_o = mat_q;
endmodule

// ===== design/dh_link_transform_top.sv =====
// top level: denavit-hartenberg link transform pipeline
// Requests come in on in_i (theta, alpha in 1/128 degree, r and d in
// Q16.16); results leave on out_o as the twelve upper entries of the
// homogeneous transform, trig entries Q2.14, translations Q16.16 saturated.
// One request enters per cycle while the output is not stalled. A request
// passes the angle reduction register, one register per cordic cell, two
// back-end stages and the output register. Throughput is one request per
// cycle while not stalled, set by the row of pipelined cordic cells.
// When the receiver stalls the whole pipeline holds; in_i.ready follows
// whether the output register can move, so no result is lost. A result
// waiting in the output register holds every stage, so no new request
// enters until that result is taken.
// Reset clears all valid bits; payload registers are not reset.
module dh_link_transform_top #(
  parameter int CordicStages = dhlt_pkg::CordicStages
) (
  input logic clk_i,
  input logic rst_ni,
  dhlt_in_if.sink    in_i,
  dhlt_out_if.source out_o
);
  logic en;
  logic v0_q;
  dhlt_pkg::lane_t l0_q, l0_d;
  logic [CordicStages:0] cv;
  dhlt_pkg::lane_t cl [CordicStages+1];
  logic pv, ov_q;
  dhlt_pkg::mat_t pm, om_q;

  assign en = !ov_q || out_o.ready;
  assign in_i.ready = en;

  function automatic dhlt_pkg::rot_t red(input logic signed [dhlt_pkg::AngW-1:0] a);
    dhlt_pkg::rot_t o;
    logic signed [18:0] m;
    logic [17:0] mu;
    logic [1:0] k;
    m = 19'(a) + 19'sd92160;
    mu = 18'(m);
    if (mu >= 18'(dhlt_pkg::AngFull)) mu = mu - 18'(dhlt_pkg::AngFull);
    if (mu >= 18'(dhlt_pkg::AngFull)) mu = mu - 18'(dhlt_pkg::AngFull);
    if (mu >= 18'(dhlt_pkg::AngFull)) mu = mu - 18'(dhlt_pkg::AngFull);
    if (mu >= 18'(dhlt_pkg::AngFull)) mu = mu - 18'(dhlt_pkg::AngFull);
    if (mu < 18'(dhlt_pkg::AngEighth)) k = 2'd0;
    else if (mu < 18'(dhlt_pkg::AngEighth + dhlt_pkg::AngQuarter)) k = 2'd1;
    else if (mu < 18'(dhlt_pkg::AngEighth + 2 * dhlt_pkg::AngQuarter)) k = 2'd2;
    else if (mu < 18'(dhlt_pkg::AngEighth + 3 * dhlt_pkg::AngQuarter)) k = 2'd3;
    else k = 2'd0;
    if (mu >= 18'(dhlt_pkg::AngEighth + 3 * dhlt_pkg::AngQuarter))
      o.z = (dhlt_pkg::ZW'(mu) - dhlt_pkg::ZW'(dhlt_pkg::AngFull)) <<< 15;
    else
      o.z = (dhlt_pkg::ZW'(mu) - dhlt_pkg::ZW'(k) * dhlt_pkg::ZW'(dhlt_pkg::AngQuarter))
            <<< 15;
    o.x = dhlt_pkg::CordicGain;
    o.y = '0;
    o.k = k;
    return o;
  endfunction

  always_comb begin
    l0_d.th = red(in_i.joint_angle);
    l0_d.al = red(in_i.twist_angle);
    l0_d.r = in_i.link_length;
    l0_d.d = in_i.link_offset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) l0_q <= l0_d;
  end

  assign cv[0] = v0_q;
  assign cl[0] = l0_q;
  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    dhlt_cell #(.Idx(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(cv[g]), .lane_i(cl[g]),
      .valid_o(cv[g+1]), .lane_o(cl[g+1])
    );
  end

  dhlt_post u_post (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cv[CordicStages]),
    .lane_i(cl[CordicStages]), .valid_o(pv), .mat_o(pm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= pv;
  end
  always_ff @(posedge clk_i) begin
    if (en) om_q <= pm;
  end
  assign out_o.valid = ov_q;
  assign out_o.m = om_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.m))
    else $error("result changed under stall");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.m.m20 == 1'b0)
    else $error("m20 not zero");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input blocked with empty output");
endmodule
